// File: hdl/rclp_pkg.sv
package rclp_pkg;

  // Line and field limits
  localparam int LineLimit = 96;
  localparam int MaxFields = 6;
  localparam int LineCntW  = $clog2(LineLimit);
  localparam int FieldCntW = $clog2(MaxFields + 1);
  localparam int FieldIdxW = (MaxFields > 1) ? $clog2(MaxFields) : 1;

  // Front-to-back queue
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Characters of interest
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Magnitude cap of a token: 2^31
  localparam logic [31:0] MagCap = 32'h8000_0000;
  localparam logic [31:0] PosMax = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ClsTerm,
    ClsNul,
    ClsComma,
    ClsDigit,
    ClsMinus,
    ClsPlus,
    ClsSpace,
    ClsOther
  } cls_e;

  typedef enum logic [1:0] {
    PhIdle,
    PhLead,
    PhNum,
    PhDead
  } phase_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic               presence;
    logic [2:0]         value_count;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic signed [31:0] value_e;
    logic signed [31:0] value_f;
  } result_t;

endpackage

// File: hdl/rclp_if.sv
interface rclp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rclp_result_if;
  logic               valid;
  logic               ready;
  logic               presence;
  logic [2:0]         value_count;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic signed [31:0] value_d;
  logic signed [31:0] value_e;
  logic signed [31:0] value_f;

  modport source (output valid, output presence, output value_count,
                  output value_a, output value_b, output value_c,
                  output value_d, output value_e, output value_f,
                  input ready);
  modport sink   (input valid, input presence, input value_count,
                  input value_a, input value_b, input value_c,
                  input value_d, input value_e, input value_f,
                  output ready);
endinterface

// File: hdl/radar_csv_line_presence_parser_top.sv
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   rx_byte[7:0]: one received character
// out_o     out  valid/ready   presence, value_count[2:0], value_a..value_f (s32)
//
// One byte per cycle sustained. A byte is classified in the front and held in
// a two-entry queue; the parser back end takes one queued byte a cycle. A
// line's CR or LF is registered in the queue, and its result then in the
// result register that drives out_o.
// A terminator waits at the head of the queue while the result register holds
// a result that has not been taken; bytes behind it collect in the queue, and
// in_i.ready drops once the queue is full. Reset clears the line state, queue
// and result valid at once; no clearing pass follows.
module radar_csv_line_presence_parser_top
  import rclp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rclp_byte_if.sink     in_i,
  rclp_result_if.source out_o
);

  // Front: classify each byte request and push it into the queue.
  logic  q_push;
  logic  q_full;
  item_t push_item;

  // Back: pop classified bytes and run the line parser.
  logic  q_pop;
  logic  q_valid;
  item_t pop_item;

  rclp_front u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (q_push),
    .item_o (push_item)
  );

  // Decouple the front from back-end stalls on a held result.
  rclp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  rclp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (pop_item),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  // A result always carries between one and the maximum number of values.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.value_count != 3'd0 &&
                     out_o.value_count <= 3'(MaxFields)))
    else $error("value_count out of range");

  // Presence flags exactly the results that hold a positive value.
  a_presence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.presence ==
      (out_o.value_a > 0 || out_o.value_b > 0 || out_o.value_c > 0 ||
       out_o.value_d > 0 || out_o.value_e > 0 || out_o.value_f > 0)))
    else $error("presence does not match values");

  // The last slot, value_f, reads as zero when the count is below six.
  a_unused_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.value_count < 3'd6) |-> out_o.value_f == 0)
    else $error("unused value slot not zero");

endmodule

// File: hdl/rclp_front.sv
module rclp_front
  import rclp_pkg::*;
(
  rclp_byte_if.sink in_i,
  input  logic  full_i,
  output logic  push_o,
  output item_t item_o
);

  function automatic item_t classify(input logic [7:0] c);
    item_t it;
    it.digit = c[3:0];
    if (c == ChCr || c == ChLf) begin
      it.cls = ClsTerm;
    end else if (c == ChNul) begin
      it.cls = ClsNul;
    end else if (c == ChComma) begin
      it.cls = ClsComma;
    end else if (c inside {[ChZero:ChNine]}) begin
      it.cls = ClsDigit;
    end else if (c == ChMinus) begin
      it.cls = ClsMinus;
    end else if (c == ChPlus) begin
      it.cls = ClsPlus;
    end else if (c inside {ChSpace, ChTab, ChVt, ChFf}) begin
      it.cls = ClsSpace;
    end else begin
      it.cls = ClsOther;
    end
    return it;
  endfunction

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign item_o     = classify(in_i.rx_byte);

endmodule

// File: hdl/rclp_queue.sv
module rclp_queue
  import rclp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: hdl/rclp_back.sv
module rclp_back
  import rclp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  pop_o,
  rclp_result_if.source out_o
);

  logic [LineCntW-1:0]  line_cnt_q, line_cnt_d;
  phase_e               phase_q, phase_d;
  logic                 first_q, first_d;
  logic                 hidden_q, hidden_d;
  logic                 minus_q, minus_d;
  logic [31:0]          acc_q, acc_d;
  logic [FieldCntW-1:0] nfld_q, nfld_d;
  logic [31:0]          fld_q [MaxFields];

  logic                 out_valid_q, out_valid_d;
  result_t              res_q, res_d;

  logic                 wr_en;
  logic [FieldIdxW-1:0] wr_idx;
  logic [31:0]          wr_val;
  logic                 emit;
  logic [35:0]          prod;
  logic [31:0]          slot [MaxFields];
  logic [31:0]          slot6 [6];
  logic                 pres;

  // Hold a terminator back while the result register is occupied.
  assign pop_o = valid_i &&
                 (item_i.cls != ClsTerm || !out_valid_q || out_o.ready);

  // Next magnitude: acc * 10 + digit, capped at 2^31
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, item_i.digit};

  // Gather stored values for the result
  always_comb begin
    pres = 1'b0;
    for (int i = 0; i < MaxFields; i++) begin
      slot[i] = (FieldCntW'(i) < nfld_q) ? fld_q[i] : 32'd0;
      if (slot[i] != 32'd0 && !slot[i][31]) begin
        pres = 1'b1;
      end
    end
    for (int i = 0; i < 6; i++) begin
      slot6[i] = (i < MaxFields) ? slot[(i < MaxFields) ? i : 0] : 32'd0;
    end
  end

  always_comb begin
    phase_e ph;
    logic   go;
    logic   skip;
    line_cnt_d  = line_cnt_q;
    phase_d     = phase_q;
    first_d     = first_q;
    hidden_d    = hidden_q;
    minus_d     = minus_q;
    acc_d       = acc_q;
    nfld_d      = nfld_q;
    wr_en       = 1'b0;
    emit        = 1'b0;
    ph          = phase_q;
    go          = 1'b1;
    skip        = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;

    if (pop_o) begin
      if (item_i.cls == ClsTerm) begin
        if (line_cnt_q != '0) begin
          emit       = (nfld_q != '0);
          line_cnt_d = '0;
          phase_d    = PhIdle;
          first_d    = 1'b0;
          hidden_d   = 1'b0;
          minus_d    = 1'b0;
          acc_d      = '0;
          nfld_d     = '0;
        end
      end else if (line_cnt_q < LineCntW'(LineLimit - 1)) begin
        line_cnt_d = line_cnt_q + 1'b1;
        if (!hidden_q) begin
          case (item_i.cls)
            ClsNul: begin
              hidden_d = 1'b1;
            end
            ClsComma: begin
              phase_d = PhIdle;
              minus_d = 1'b0;
              acc_d   = '0;
            end
            default: begin
              if (ph == PhIdle) begin
                if (!first_q) begin
                  first_d = 1'b1;
                  skip = !(item_i.cls inside {ClsDigit, ClsMinus, ClsPlus});
                end
                if (nfld_q >= FieldCntW'(MaxFields)) begin
                  skip = 1'b1;
                end
                if (skip) begin
                  ph = PhDead;
                  go = 1'b0;
                end else begin
                  nfld_d  = nfld_q + 1'b1;
                  acc_d   = '0;
                  minus_d = 1'b0;
                  ph      = PhLead;
                  wr_en   = 1'b1;
                end
              end
              if (go && ph == PhLead) begin
                if (item_i.cls == ClsSpace) begin
                  go = 1'b0;
                end else if (item_i.cls inside {ClsMinus, ClsPlus}) begin
                  minus_d = (item_i.cls == ClsMinus);
                  ph      = PhNum;
                  wr_en   = 1'b1;
                  go      = 1'b0;
                end else begin
                  ph = PhNum;
                end
              end
              if (go && ph == PhNum) begin
                if (item_i.cls == ClsDigit) begin
                  acc_d = (prod > {4'd0, MagCap}) ? MagCap : prod[31:0];
                  wr_en = 1'b1;
                end else begin
                  ph = PhDead;
                end
              end
              phase_d = ph;
            end
          endcase
        end
      end else begin
        // Drop the byte and clear the overlong line.
        line_cnt_d = '0;
        phase_d    = PhIdle;
        first_d    = 1'b0;
        hidden_d   = 1'b0;
        minus_d    = 1'b0;
        acc_d      = '0;
        nfld_d     = '0;
      end
    end

    if (emit) begin
      out_valid_d       = 1'b1;
      res_d.presence    = pres;
      res_d.value_count = nfld_q[2:0];
      res_d.value_a     = slot6[0];
      res_d.value_b     = slot6[1];
      res_d.value_c     = slot6[2];
      res_d.value_d     = slot6[3];
      res_d.value_e     = slot6[4];
      res_d.value_f     = slot6[5];
    end
  end

  assign wr_idx = FieldIdxW'(nfld_d - 1'b1);
  assign wr_val = minus_d ? (32'd0 - acc_d) : (acc_d[31] ? PosMax : acc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q  <= '0;
      phase_q     <= PhIdle;
      first_q     <= 1'b0;
      hidden_q    <= 1'b0;
      minus_q     <= 1'b0;
      acc_q       <= '0;
      nfld_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_cnt_q  <= line_cnt_d;
      phase_q     <= phase_d;
      first_q     <= first_d;
      hidden_q    <= hidden_d;
      minus_q     <= minus_d;
      acc_q       <= acc_d;
      nfld_q      <= nfld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (wr_en) begin
      fld_q[wr_idx] <= wr_val;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.presence    = res_q.presence;
  assign out_o.value_count = res_q.value_count;
  assign out_o.value_a     = res_q.value_a;
  assign out_o.value_b     = res_q.value_b;
  assign out_o.value_c     = res_q.value_c;
  assign out_o.value_d     = res_q.value_d;
  assign out_o.value_e     = res_q.value_e;
  assign out_o.value_f     = res_q.value_f;

endmodule

// File: tb/sv/radar_csv_line_presence_parser_top_tb.sv
module radar_csv_line_presence_parser_top_tb
  import rclp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Run bounds: the drain wait covers the queue and result register path with margin,
  // and the cycle limit is many times the slowest legal run.
  localparam int DrainCycles   = 20;
  localparam int CycleLimit    = 400000;
  localparam int BytesPerPhase = 425;

  logic clk_i = 1'b0;
  logic rst_ni;

  rclp_byte_if   in_if ();
  rclp_result_if out_if ();

  radar_csv_line_presence_parser_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Bytes waiting for the driver, and line results waiting for the monitor.
  logic [7:0] pending_bytes[$];
  result_t    expected_lines[$];

  int unsigned bytes_queued;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned mismatches;
  int unsigned cycle_count;
  result_t     monitor_want;

  // Shadow copy of the line parser state.
  int unsigned line_len;
  phase_e      tok_phase;
  logic        first_tok_started;
  logic        rest_muted;
  logic        tok_negative;
  logic [35:0] tok_mag;
  int unsigned fields_seen;
  logic [31:0] field_vals[MaxFields];

  string limit_numbers[6] = '{"2147483647", "2147483648", "-2147483648",
                              "-2147483649", "4294967296", "-0"};

  // ------------------------------------------------------------------------
  // Line parser prediction
  // ------------------------------------------------------------------------

  function automatic void clear_line();
    line_len          = 0;
    tok_phase         = PhIdle;
    first_tok_started = 1'b0;
    rest_muted        = 1'b0;
    tok_negative      = 1'b0;
    tok_mag           = '0;
    fields_seen       = 0;
    for (int i = 0; i < MaxFields; i++) field_vals[i] = '0;
  endfunction

  // Record the running value of the current token, saturated to 32 bits.
  function automatic void store_token_value();
    logic [31:0] v;
    if (tok_negative) begin
      v = 32'd0 - tok_mag[31:0];
    end else begin
      v = (tok_mag >= MagCap) ? PosMax : tok_mag[31:0];
    end
    if (fields_seen >= 1 && fields_seen <= MaxFields) field_vals[fields_seen - 1] = v;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    logic is_dig;
    logic dropped;
    is_dig = (c >= ChZero && c <= ChNine);
    if (rest_muted) return;
    // A NUL hides the rest of its line.
    if (c == ChNul) begin
      rest_muted = 1'b1;
      return;
    end
    if (c == ChComma) begin
      tok_phase    = PhIdle;
      tok_negative = 1'b0;
      tok_mag      = '0;
      return;
    end
    if (tok_phase == PhIdle) begin
      dropped = 1'b0;
      // The header token is dropped unless it opens with a digit or a sign.
      if (!first_tok_started) begin
        first_tok_started = 1'b1;
        dropped = !(is_dig || c == ChMinus || c == ChPlus);
      end
      if (fields_seen >= MaxFields) dropped = 1'b1;
      if (dropped) begin
        tok_phase = PhDead;
        return;
      end
      fields_seen++;
      tok_mag      = '0;
      tok_negative = 1'b0;
      tok_phase    = PhLead;
      store_token_value();
    end
    if (tok_phase == PhLead) begin
      if (c == ChSpace || (c >= ChTab && c <= ChCr)) return;
      if (c == ChMinus || c == ChPlus) begin
        tok_negative = (c == ChMinus);
        tok_phase    = PhNum;
        store_token_value();
        return;
      end
      tok_phase = PhNum;
    end
    if (tok_phase == PhNum) begin
      if (is_dig) begin
        tok_mag = tok_mag * 36'd10 + 36'(c - ChZero);
        if (tok_mag > MagCap) tok_mag = MagCap;
        store_token_value();
      end else begin
        tok_phase = PhDead;
      end
    end
  endfunction

  // Advance the shadow parser by one accepted byte; queue a result on a
  // terminator that closes a line with values.
  function automatic void predict_byte(logic [7:0] c);
    result_t r;
    if (c == ChLf || c == ChCr) begin
      if (line_len != 0) begin
        if (fields_seen != 0) begin
          r = '0;
          for (int i = 0; i < fields_seen && i < MaxFields; i++) begin
            if (field_vals[i] != 0 && !field_vals[i][31]) r.presence = 1'b1;
          end
          r.value_count = fields_seen[2:0];
          r.value_a     = field_vals[0];
          r.value_b     = field_vals[1];
          r.value_c     = field_vals[2];
          r.value_d     = field_vals[3];
          r.value_e     = field_vals[4];
          r.value_f     = field_vals[5];
          expected_lines.push_back(r);
        end
        clear_line();
      end
    end else if (line_len < LineLimit - 1) begin
      line_len++;
      parse_char(c);
    end else begin
      // Line overrun: drop the byte and the whole line.
      clear_line();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus builders
  // ------------------------------------------------------------------------

  function automatic void push_byte(logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChVt;
      default: return ChFf;
    endcase
  endfunction

  function automatic logic [7:0] pick_terminator();
    return $urandom_range(1) ? ChCr : ChLf;
  endfunction

  // One numeric field: optional blanks, optional sign, a few digits, now and
  // then a saturation boundary, a bare sign or trailing junk.
  function automatic void push_number_token();
    int pick;
    int ndig;
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0) push_byte(pick_blank());
    pick = $urandom_range(99);
    if (pick < 6) begin
      push_text(limit_numbers[$urandom_range(5)]);
      return;
    end
    if (pick < 30) push_byte(ChMinus);
    else if (pick < 40) push_byte(ChPlus);
    pick = $urandom_range(99);
    ndig = (pick < 4)  ? 0 :
           (pick < 70) ? $urandom_range(1, 3) :
           (pick < 90) ? $urandom_range(4, 9) : $urandom_range(10, 12);
    repeat (ndig) push_byte(8'(ChZero + $urandom_range(9)));
    if ($urandom_range(9) == 0) push_text($urandom_range(1) ? ".5" : " x");
  endfunction

  function automatic void push_random_line();
    int kind;
    int hdr;
    int ntok;
    kind = $urandom_range(99);
    if (kind < 72) begin
      // Well-formed record: optional header, then comma-separated numbers.
      hdr = $urandom_range(3);
      if (hdr == 0) begin
        push_text("rd");
      end else if (hdr == 1) begin
        push_byte(pick_blank());
        push_text("7");
      end
      ntok = ($urandom_range(9) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
      for (int i = 0; i < ntok; i++) begin
        if (i != 0 || hdr < 2) push_byte(ChComma);
        if ($urandom_range(15) == 0) push_byte(ChComma);
        if ($urandom_range(39) == 0) push_byte(ChNul);
        push_number_token();
      end
      if ($urandom_range(19) == 0) push_byte(ChComma);
      if ($urandom_range(3) == 0) push_byte(ChCr);
      push_byte(pick_terminator());
    end else if (kind < 90) begin
      // Raw noise over the full byte range.
      repeat ($urandom_range(1, 24)) push_byte(8'($urandom_range(255)));
      push_byte(pick_terminator());
    end else if (kind < 95) begin
      // Long lines straddle the length limit.
      repeat ($urandom_range(90, 110)) begin
        push_byte(($urandom_range(3) == 0) ? ChComma : 8'(ChZero + $urandom_range(9)));
      end
      push_byte(pick_terminator());
    end else begin
      // Empty lines and comma-only lines.
      repeat ($urandom_range(3)) push_byte(ChComma);
      push_byte(pick_terminator());
    end
  endfunction

  // ------------------------------------------------------------------------
  // Driver: present the head of the pending queue, hold it until taken.
  // ------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_byte(in_if.rx_byte);
        void'(pending_bytes.pop_front());
      end
      // Hold a request that was not taken; otherwise offer the next byte
      // or idle.
      if (!in_if.valid || in_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.rx_byte <= pending_bytes[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest expected line.
  // ------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s at %0t: expected %0d (0x%h), got %0d (0x%h)",
                 name, $realtime, $signed(want), want, $signed(got), got);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_lines.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          monitor_want = expected_lines.pop_front();
          check_field("presence", 32'(monitor_want.presence), 32'(out_if.presence));
          check_field("value_count", 32'(monitor_want.value_count),
                      32'(out_if.value_count));
          check_field("value_a", monitor_want.value_a, out_if.value_a);
          check_field("value_b", monitor_want.value_b, out_if.value_b);
          check_field("value_c", monitor_want.value_c, out_if.value_c);
          check_field("value_d", monitor_want.value_d, out_if.value_d);
          check_field("value_e", monitor_want.value_e, out_if.value_e);
          check_field("value_f", monitor_want.value_f, out_if.value_f);
        end
      end
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Sequencer: reset, directed lines, then random lines under four idling
  // profiles, then drain.
  // ------------------------------------------------------------------------

  int unsigned src_profile[4]  = '{0, 81, 0, 38};
  int unsigned sink_profile[4] = '{0, 0, 81, 38};

  initial begin
    int unsigned phase_start;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.rx_byte  = '0;
    out_if.ready   = 1'b0;
    bytes_queued   = 0;
    mismatches     = 0;
    cycle_count    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    clear_line();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed lines. An empty line gives nothing.
    push_byte(ChLf);
    // Header word dropped, blank-led 9 with junk, then a bare sign.
    push_text("h, 9z,+");
    push_byte(ChCr);
    // Negative overflow, an empty token, and a seventh field that is ignored.
    push_text("-99999999999,,1,2,3,4,5,6");
    push_byte(ChLf);
    // A NUL hides the rest of the line.
    push_text("5");
    push_byte(ChNul);
    push_text(",7");
    push_byte(ChLf);
    // High-bit header byte dropped; CR LF leaves an empty line behind.
    push_byte(8'hFF);
    push_text(",1");
    push_byte(ChCr);
    push_byte(ChLf);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_profile[ph];
      sink_stall_pct = sink_profile[ph];
      phase_start    = bytes_queued;
      while (bytes_queued - phase_start < BytesPerPhase) push_random_line();
      while (pending_bytes.size() != 0) @(posedge clk_i);
    end

    // Drain: wait for every expected line, then let the pipeline settle.
    while (pending_bytes.size() != 0 || expected_lines.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
